[hw/rtl/pfc_pkg.sv]
// ----------------------------------------------------------------------------
// pfc_pkg: shared types and constants of the Playfair digraph cipher
// Item layouts, opcodes, status codes and the grid geometry helper.
// ----------------------------------------------------------------------------
package pfc_pkg;

    // Geometry of the symbol alphabet and the key grid
    localparam int SYM_W      = 7;                  // symbol width
    localparam int ROW_W      = 3;                  // grid row index width
    localparam int COL_W      = 4;                  // grid column index width
    localparam int CELL_W     = ROW_W + COL_W;      // cell index, row-major
    localparam int COLS_W     = 5;                  // column count width
    localparam int ALPHABET   = 2 ** SYM_W;         // symbols in the alphabet
    localparam int CELL_COUNT = 2 ** CELL_W;        // cells in the full grid

    localparam logic [COLS_W-1:0] COLS_MIN   = 5'd2;
    localparam logic [COLS_W-1:0] COLS_MAX   = 5'd16;
    localparam logic [COLS_W-1:0] COLS_RESET = 5'd16;

    // Output queue
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = 2;
    localparam int OUT_CNT_W = 3;

    // Opcodes
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_ENCODE = 2'd1;
    localparam logic [1:0] OP_DECODE = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [SYM_W-1:0] symbol_first;
        logic [SYM_W-1:0] symbol_second;
        logic             second_missing;
        logic [ROW_W-1:0] cell_row;
        logic [COL_W-1:0] cell_column;
    } t_in_item;

    typedef struct packed {
        logic [SYM_W-1:0] out_first;
        logic [SYM_W-1:0] out_second;
        logic [1:0]       status;
    } t_out_item;

    // What one lane found for its symbol
    typedef struct packed {
        logic              found;
        logic [CELL_W-1:0] dest_cell;
    } t_lane_res;

    // Grid reads of both lanes, handed to the merge stage
    typedef struct packed {
        logic             found;
        logic             first_valid;
        logic [SYM_W-1:0] first_sym;
        logic             second_valid;
        logic [SYM_W-1:0] second_sym;
    } t_pair_rd;

    // Clear bit 0, clamp to 2..16
    function automatic logic [COLS_W-1:0] active_columns(input logic [COLS_W-1:0] raw);
        logic [COLS_W-1:0] c;
        c = {raw[COLS_W-1:1], 1'b0};
        if (c < COLS_MIN) begin
            c = COLS_MIN;
        end else if (c > COLS_MAX) begin
            c = COLS_MAX;
        end
        return c;
    endfunction

endpackage

[hw/rtl/playfair_digraph_cipher.sv]
// ----------------------------------------------------------------------------
// playfair_digraph_cipher: Playfair digraph cipher, one pair per cycle while not stalled
// Key loads fill a grid of symbols; encode and decode items map a symbol
// pair through the grid with the Playfair row, column and rectangle rules.
// ----------------------------------------------------------------------------
// The block takes one item per clock while not stalled and keeps taking
// them back to back: key loads, encodes and decodes may follow each other
// in any mix. A result for an encode or decode item passes a position
// lookup, a grid lookup and a merge into the result queue; key loads and
// opcode 3 give no result. The two table lookups run in a row, each a
// registered memory read. Both symbols of a pair go through two identical
// lanes, and a merge stage forms the status. The input is stalled
// only when the four-entry result queue plus results still in the pipeline
// already fill it, so a stalled output costs throughput only after the queue
// backs up. The columns register must be written while the block is idle.
// ----------------------------------------------------------------------------
module playfair_digraph_cipher (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration
    input  logic                       i_cfg_we,
    input  logic [pfc_pkg::COLS_W-1:0] i_cfg_wdata,
    // input items
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  pfc_pkg::t_in_item          i_in_item,
    // result items
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output pfc_pkg::t_out_item         o_out_item
);

    localparam int SW = pfc_pkg::SYM_W;
    localparam int CW = pfc_pkg::CELL_W;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [pfc_pkg::COLS_W-1:0] r_columns;
    logic [pfc_pkg::COLS_W-1:0] cols_act;
    logic [pfc_pkg::COLS_W-2:0] rows_act;

    assign cols_act = pfc_pkg::active_columns(r_columns);
    assign rows_act = cols_act[pfc_pkg::COLS_W-1:1];

    // ------------------------------------------------------------------
    // Tables. The position table maps symbol -> cell, the grid maps
    // cell -> symbol. The grid is kept twice: one copy serves the two lane
    // reads of the second stage, the other the occupant read of a key load.
    // Valid bits live in flops so reset empties both tables at once.
    // ------------------------------------------------------------------
    logic [CW-1:0]                   r_pos_mem    [pfc_pkg::ALPHABET];
    logic [SW-1:0]                   r_grid_a_mem [pfc_pkg::CELL_COUNT];
    logic [SW-1:0]                   r_grid_b_mem [pfc_pkg::CELL_COUNT];
    logic [pfc_pkg::ALPHABET-1:0]    r_pos_valid;
    logic [pfc_pkg::ALPHABET-1:0]    n_pos_valid;
    logic [pfc_pkg::CELL_COUNT-1:0]  r_grid_valid;
    logic [pfc_pkg::CELL_COUNT-1:0]  n_grid_valid;

    // ------------------------------------------------------------------
    // Stage 0: accept, read the position table for both symbols and the
    // grid copy for a load's target cell
    // ------------------------------------------------------------------
    logic           in_acc;
    logic [SW-1:0]  sym_a;
    logic [SW-1:0]  sym_b;
    logic [CW-1:0]  ld_cell;
    logic           ld_ok;
    logic           is_pair;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign sym_a   = i_in_item.symbol_first;
    // odd tail: second symbol is taken as 0
    assign sym_b   = i_in_item.second_missing ? '0 : i_in_item.symbol_second;
    assign ld_cell = {i_in_item.cell_row, i_in_item.cell_column};
    assign ld_ok   = ({1'b0, i_in_item.cell_row} < rows_act)
                     && ({1'b0, i_in_item.cell_column} < cols_act);
    assign is_pair = (i_in_item.opcode == pfc_pkg::OP_ENCODE)
                     || (i_in_item.opcode == pfc_pkg::OP_DECODE);

    // Stage 1 registers
    logic           r1_v;
    logic           r1_load;
    logic           r1_decode;
    logic [SW-1:0]  r1_sym;
    logic [CW-1:0]  r1_cell;
    logic [CW-1:0]  r_pos_rd_a;
    logic [CW-1:0]  r_pos_rd_b;
    logic           r1_pv_a;
    logic           r1_pv_b;
    logic           r1_byp_a;
    logic           r1_byp_b;
    logic [CW-1:0]  r1_byp_cell;
    logic [SW-1:0]  r_grid_b_rd;
    logic           r1_occ_v;
    logic           r1_byp_occ;
    logic [SW-1:0]  r1_byp_sym;

    // ------------------------------------------------------------------
    // Stage 1: a load writes the tables; a pair runs the two lanes and
    // reads the grid at the cells they chose
    // ------------------------------------------------------------------
    logic                 ld_we;
    logic [CW-1:0]        pos_a;
    logic [CW-1:0]        pos_b;
    logic [CW-1:0]        old_cell;
    logic [SW-1:0]        occ_sym;
    pfc_pkg::t_lane_res   lane_first;
    pfc_pkg::t_lane_res   lane_second;

    assign ld_we = r1_v && r1_load;

    // A load one stage ahead wrote at the same edge as these reads: take its
    // data instead of the stale memory word
    assign pos_a    = r1_byp_a ? r1_byp_cell : r_pos_rd_a;
    assign pos_b    = r1_byp_b ? r1_byp_cell : r_pos_rd_b;
    assign old_cell = pos_a;
    assign occ_sym  = r1_byp_occ ? r1_byp_sym : r_grid_b_rd;

    // Keep both tables consistent: empty the symbol's former cell, drop the
    // former occupant of the target cell, then mark the new pairing
    always_comb begin
        n_pos_valid  = r_pos_valid;
        n_grid_valid = r_grid_valid;
        if (ld_we) begin
            if (r1_occ_v) begin
                n_pos_valid[occ_sym] = 1'b0;
            end
            if (r1_pv_a) begin
                n_grid_valid[old_cell] = 1'b0;
            end
            n_pos_valid[r1_sym]   = 1'b1;
            n_grid_valid[r1_cell] = 1'b1;
        end
    end

    pfc_lane u_lane_first (
        .i_own_valid (r1_pv_a),
        .i_own_pos   (pos_a),
        .i_peer_pos  (pos_b),
        .i_decode    (r1_decode),
        .i_columns   (cols_act),
        .o_res       (lane_first)
    );

    pfc_lane u_lane_second (
        .i_own_valid (r1_pv_b),
        .i_own_pos   (pos_b),
        .i_peer_pos  (pos_a),
        .i_decode    (r1_decode),
        .i_columns   (cols_act),
        .o_res       (lane_second)
    );

    // Stage 2 registers
    logic           r2_v;
    logic           r2_found;
    logic           r2_gv_first;
    logic           r2_gv_second;
    logic [SW-1:0]  r_grid_rd_first;
    logic [SW-1:0]  r_grid_rd_second;

    // ------------------------------------------------------------------
    // Stage 2: merge the lanes and push the result item
    // ------------------------------------------------------------------
    pfc_pkg::t_pair_rd  pair_rd;
    pfc_pkg::t_out_item merged;

    always_comb begin
        pair_rd.found        = r2_found;
        pair_rd.first_valid  = r2_gv_first;
        pair_rd.first_sym    = r_grid_rd_first;
        pair_rd.second_valid = r2_gv_second;
        pair_rd.second_sym   = r_grid_rd_second;
    end

    pfc_merge u_merge (
        .i_rd   (pair_rd),
        .o_item (merged)
    );

    logic [pfc_pkg::OUT_CNT_W-1:0] q_count;
    logic [pfc_pkg::OUT_CNT_W-1:0] results_owed;

    pfc_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r2_v),
        .i_data  (merged),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_data  (o_out_item),
        .o_count (q_count)
    );

    // Count queued results plus those still in flight; hold the input while
    // one more could overflow the queue
    assign results_owed = q_count
                          + {2'b00, r1_v && !r1_load}
                          + {2'b00, r2_v};
    assign o_in_stall   = (results_owed >= pfc_pkg::OUT_CNT_W'(pfc_pkg::OUT_DEPTH));

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns    <= pfc_pkg::COLS_RESET;
            r_pos_valid  <= '0;
            r_grid_valid <= '0;
            r1_v         <= 1'b0;
            r2_v         <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_columns <= i_cfg_wdata;
            end
            r_pos_valid  <= n_pos_valid;
            r_grid_valid <= n_grid_valid;
            r1_v <= in_acc && (is_pair || ((i_in_item.opcode == pfc_pkg::OP_LOAD) && ld_ok));
            r2_v <= r1_v && !r1_load;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers and memories
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        // stage 0 -> 1
        r1_load     <= (i_in_item.opcode == pfc_pkg::OP_LOAD);
        r1_decode   <= (i_in_item.opcode == pfc_pkg::OP_DECODE);
        r1_sym      <= sym_a;
        r1_cell     <= ld_cell;
        r_pos_rd_a  <= r_pos_mem[sym_a];
        r_pos_rd_b  <= r_pos_mem[sym_b];
        r1_pv_a     <= n_pos_valid[sym_a];
        r1_pv_b     <= n_pos_valid[sym_b];
        r1_byp_a    <= ld_we && (r1_sym == sym_a);
        r1_byp_b    <= ld_we && (r1_sym == sym_b);
        r1_byp_cell <= r1_cell;
        r_grid_b_rd <= r_grid_b_mem[ld_cell];
        r1_occ_v    <= n_grid_valid[ld_cell];
        r1_byp_occ  <= ld_we && (r1_cell == ld_cell);
        r1_byp_sym  <= r1_sym;

        // stage 1 -> 2
        r2_found         <= lane_first.found && lane_second.found;
        r2_gv_first      <= r_grid_valid[lane_first.dest_cell];
        r2_gv_second     <= r_grid_valid[lane_second.dest_cell];
        r_grid_rd_first  <= r_grid_a_mem[lane_first.dest_cell];
        r_grid_rd_second <= r_grid_a_mem[lane_second.dest_cell];

        // table writes of a load
        if (ld_we) begin
            r_pos_mem[r1_sym]     <= r1_cell;
            r_grid_a_mem[r1_cell] <= r1_sym;
            r_grid_b_mem[r1_cell] <= r1_sym;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Queue plus results in flight never exceed the queue depth
    a_no_overflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        results_owed <= pfc_pkg::OUT_CNT_W'(pfc_pkg::OUT_DEPTH))
        else $error("result queue overcommitted");

    // A load leaves its symbol present in the position table
    a_load_sym : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ld_we |=> r_pos_valid[$past(r1_sym)])
        else $error("loaded symbol not marked present");

    // A load leaves its target cell filled in the grid
    a_load_cell : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ld_we |=> r_grid_valid[$past(r1_cell)])
        else $error("loaded cell not marked filled");

endmodule

[hw/rtl/pfc_lane.sv]
// ----------------------------------------------------------------------------
// pfc_lane: per-symbol cipher lane
// Checks that one symbol sits inside the active grid and works out the cell
// that replaces it, given the partner symbol's position.
// ----------------------------------------------------------------------------
module pfc_lane (
    input  logic                       i_own_valid,
    input  logic [pfc_pkg::CELL_W-1:0] i_own_pos,
    input  logic [pfc_pkg::CELL_W-1:0] i_peer_pos,
    input  logic                       i_decode,
    input  logic [pfc_pkg::COLS_W-1:0] i_columns,
    output pfc_pkg::t_lane_res         o_res
);

    logic [pfc_pkg::COLS_W-2:0] rows;
    logic [pfc_pkg::ROW_W-1:0]  own_row;
    logic [pfc_pkg::COL_W-1:0]  own_col;
    logic [pfc_pkg::ROW_W-1:0]  peer_row;
    logic [pfc_pkg::COL_W-1:0]  peer_col;
    logic [pfc_pkg::COLS_W-1:0] col_inc;
    logic [pfc_pkg::COLS_W-1:0] col_up;
    logic [pfc_pkg::COLS_W-1:0] col_dn;
    logic [pfc_pkg::COLS_W-2:0] row_inc;
    logic [pfc_pkg::COLS_W-2:0] row_up;
    logic [pfc_pkg::COLS_W-2:0] row_dn;
    logic [pfc_pkg::COL_W-1:0]  next_col;
    logic [pfc_pkg::ROW_W-1:0]  next_row;

    assign rows     = i_columns[pfc_pkg::COLS_W-1:1];
    assign own_row  = i_own_pos[pfc_pkg::CELL_W-1:pfc_pkg::COL_W];
    assign own_col  = i_own_pos[pfc_pkg::COL_W-1:0];
    assign peer_row = i_peer_pos[pfc_pkg::CELL_W-1:pfc_pkg::COL_W];
    assign peer_col = i_peer_pos[pfc_pkg::COL_W-1:0];

    // Step one column or one row with wrap, forward to encode, back to decode
    assign col_inc = {1'b0, own_col} + 5'd1;
    assign col_up  = (col_inc == i_columns) ? '0 : col_inc;
    assign col_dn  = (own_col == '0) ? (i_columns - 5'd1) : ({1'b0, own_col} - 5'd1);
    assign row_inc = {1'b0, own_row} + 4'd1;
    assign row_up  = (row_inc == rows) ? '0 : row_inc;
    assign row_dn  = (own_row == '0) ? (rows - 4'd1) : ({1'b0, own_row} - 4'd1);

    assign next_col = i_decode ? col_dn[pfc_pkg::COL_W-1:0] : col_up[pfc_pkg::COL_W-1:0];
    assign next_row = i_decode ? row_dn[pfc_pkg::ROW_W-1:0] : row_up[pfc_pkg::ROW_W-1:0];

    always_comb begin
        o_res.found = i_own_valid
                      && ({1'b0, own_row} < rows)
                      && ({1'b0, own_col} < i_columns);
        if (own_row == peer_row) begin
            o_res.dest_cell = {own_row, next_col};
        end else if (own_col == peer_col) begin
            o_res.dest_cell = {next_row, own_col};
        end else begin
            // rectangle: keep the row, take the partner's column
            o_res.dest_cell = {own_row, peer_col};
        end
    end

endmodule

[hw/rtl/pfc_merge.sv]
// ----------------------------------------------------------------------------
// pfc_merge: lane merge stage
// Combines the grid reads of both lanes into one result item and status.
// ----------------------------------------------------------------------------
module pfc_merge (
    input  pfc_pkg::t_pair_rd  i_rd,
    output pfc_pkg::t_out_item o_item
);

    always_comb begin
        o_item.out_first  = '0;
        o_item.out_second = '0;
        if (!i_rd.found) begin
            o_item.status = pfc_pkg::ST_ABSENT;
        end else if (!i_rd.first_valid || !i_rd.second_valid) begin
            o_item.status = pfc_pkg::ST_EMPTY;
        end else begin
            o_item.status     = pfc_pkg::ST_OK;
            o_item.out_first  = i_rd.first_sym;
            o_item.out_second = i_rd.second_sym;
        end
    end

endmodule

[hw/rtl/pfc_out_fifo.sv]
// ----------------------------------------------------------------------------
// pfc_out_fifo: result queue
// Small queue that decouples the cipher pipeline from output stalls.
// ----------------------------------------------------------------------------
module pfc_out_fifo (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  pfc_pkg::t_out_item            i_data,
    input  logic                          i_stall,
    output logic                          o_valid,
    output pfc_pkg::t_out_item            o_data,
    output logic [pfc_pkg::OUT_CNT_W-1:0] o_count
);

    pfc_pkg::t_out_item                r_mem [pfc_pkg::OUT_DEPTH];
    logic [pfc_pkg::OUT_PTR_W-1:0]     r_wr_ptr;
    logic [pfc_pkg::OUT_PTR_W-1:0]     r_rd_ptr;
    logic [pfc_pkg::OUT_CNT_W-1:0]     r_count;
    logic                              pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;
    assign pop     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 2'd1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
            r_count <= r_count + {2'b00, i_push} - {2'b00, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[verif/tb_playfair_digraph_cipher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_playfair_digraph_cipher: self-checking bench for the Playfair cipher
// Writes several grid widths, loads keys cell by cell, and streams encode
// and decode pairs with random input gaps and output stalls. Each result is
// checked against a grid copy that the bench keeps and updates item by item.
// ----------------------------------------------------------------------------
module tb_playfair_digraph_cipher;

    localparam int SYM_W      = pfc_pkg::SYM_W;
    localparam int ROW_W      = pfc_pkg::ROW_W;
    localparam int COL_W      = pfc_pkg::COL_W;
    localparam int COLS_W     = pfc_pkg::COLS_W;
    localparam int ALPHABET   = pfc_pkg::ALPHABET;
    localparam int CELL_COUNT = pfc_pkg::CELL_COUNT;

    localparam int CLK_HALF       = 4;
    localparam int GRID_STRIDE    = 16;    // row pitch of the cell index
    localparam int DRAIN_CYCLES   = 8;     // pipeline is three deep, pad it
    localparam int WATCHDOG_LIMIT = 1000;  // cycles without any handshake
    localparam int KEY_LOAD_CAP   = 48;    // loads per key on wide grids
    localparam int PAIRS_PER_KEY  = 14;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [COLS_W-1:0]  i_cfg_wdata;
    logic               i_in_valid;
    logic               o_in_stall;
    pfc_pkg::t_in_item  i_in_item;
    logic               o_out_valid;
    logic               i_out_stall;
    pfc_pkg::t_out_item o_out_item;

    // Bench copy of the block state
    int unsigned       cell_of_symbol [ALPHABET];    // 0 absent, else cell + 1
    int unsigned       symbol_in_cell [CELL_COUNT];  // 0 empty, else symbol + 1
    logic [COLS_W-1:0] columns_reg;

    pfc_pkg::t_out_item pending_pairs[$];   // results still owed by the block
    logic [SYM_W-1:0]   key_syms[$];        // key symbols loaded since the last width change
    int                 error_count;
    int                 quiet_cycles;
    int                 out_hold;           // stall cycles left before the next result
    bit                 in_burst;           // stretches with no input gaps
    bit                 out_burst;          // stretches with no output stalls

    playfair_digraph_cipher u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Grid model
    // ------------------------------------------------------------------

    // Effective width: drop bit 0, keep within 2..16
    function automatic int grid_width();
        int c;
        c = int'(columns_reg) & ~1;
        if (c < 2) begin
            c = 2;
        end
        if (c > 16) begin
            c = 16;
        end
        return c;
    endfunction

    // A symbol counts as present only while its cell lies inside the grid
    function automatic bit locate_symbol(input int sym, input int cols,
                                         output int row, output int col);
        int unsigned pos;
        pos = cell_of_symbol[sym];
        if (pos == 0) begin
            return 1'b0;
        end
        row = (pos - 1) / GRID_STRIDE;
        col = (pos - 1) % GRID_STRIDE;
        return (row < cols / 2) && (col < cols);
    endfunction

    // Apply one accepted item to the grid copy; queue the pair it owes, if any
    function automatic void grid_cipher_step(input pfc_pkg::t_in_item it);
        int cols, rows, s1, s2, idx;
        int r1, c1, r2, c2, n1r, n1c, n2r, n2c, cstep, rstep;
        int unsigned old_cell, occupant, v1, v2;
        pfc_pkg::t_out_item res;
        cols = grid_width();
        rows = cols / 2;
        s1   = int'(it.symbol_first);
        s2   = int'(it.symbol_second);
        case (it.opcode)
            pfc_pkg::OP_LOAD: begin
                // Out-of-grid loads are dropped; otherwise keep both tables in step
                if (int'(it.cell_row) < rows && int'(it.cell_column) < cols) begin
                    idx      = int'(it.cell_row) * GRID_STRIDE + int'(it.cell_column);
                    old_cell = cell_of_symbol[s1];
                    if (old_cell != 0) begin
                        symbol_in_cell[old_cell - 1] = 0;
                    end
                    occupant = symbol_in_cell[idx];
                    if (occupant != 0) begin
                        cell_of_symbol[occupant - 1] = 0;
                    end
                    cell_of_symbol[s1]  = idx + 1;
                    symbol_in_cell[idx] = s1 + 1;
                end
            end
            pfc_pkg::OP_ENCODE, pfc_pkg::OP_DECODE: begin
                res = '0;
                if (it.second_missing) begin
                    s2 = 0;
                end
                if (it.opcode == pfc_pkg::OP_ENCODE) begin
                    cstep = 1;
                    rstep = 1;
                end else begin
                    cstep = cols - 1;
                    rstep = rows - 1;
                end
                if (!locate_symbol(s1, cols, r1, c1) || !locate_symbol(s2, cols, r2, c2)) begin
                    res.status = pfc_pkg::ST_ABSENT;
                end else begin
                    if (r1 == r2) begin
                        n1r = r1; n1c = (c1 + cstep) % cols;
                        n2r = r2; n2c = (c2 + cstep) % cols;
                    end else if (c1 == c2) begin
                        n1r = (r1 + rstep) % rows; n1c = c1;
                        n2r = (r2 + rstep) % rows; n2c = c2;
                    end else begin
                        n1r = r1; n1c = c2;
                        n2r = r2; n2c = c1;
                    end
                    v1 = symbol_in_cell[n1r * GRID_STRIDE + n1c];
                    v2 = symbol_in_cell[n2r * GRID_STRIDE + n2c];
                    if (v1 == 0 || v2 == 0) begin
                        res.status = pfc_pkg::ST_EMPTY;
                    end else begin
                        res.status     = pfc_pkg::ST_OK;
                        res.out_first  = SYM_W'(v1 - 1);
                        res.out_second = SYM_W'(v2 - 1);
                    end
                end
                pending_pairs = {pending_pairs, res};
            end
            default: begin
                // OP_NONE: block drops it
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Item builders; fields the opcode ignores get random content
    // ------------------------------------------------------------------
    function automatic pfc_pkg::t_in_item load_item(input logic [SYM_W-1:0] sym,
                                                    input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        pfc_pkg::t_in_item it;
        it.opcode         = pfc_pkg::OP_LOAD;
        it.symbol_first   = sym;
        it.symbol_second  = SYM_W'($urandom);
        it.second_missing = 1'($urandom);
        it.cell_row       = row;
        it.cell_column    = col;
        return it;
    endfunction

    function automatic pfc_pkg::t_in_item pair_item(input logic [1:0] op,
                                                    input logic [SYM_W-1:0] s1,
                                                    input logic [SYM_W-1:0] s2,
                                                    input logic missing);
        pfc_pkg::t_in_item it;
        it.opcode         = op;
        it.symbol_first   = s1;
        it.symbol_second  = s2;
        it.second_missing = missing;
        it.cell_row       = ROW_W'($urandom);
        it.cell_column    = COL_W'($urandom);
        return it;
    endfunction

    // Mostly a symbol of the current key, sometimes any symbol at all
    function automatic logic [SYM_W-1:0] pick_symbol();
        if (key_syms.size() > 0 && $urandom_range(0, 4) != 0) begin
            return key_syms[$urandom_range(0, key_syms.size() - 1)];
        end
        return SYM_W'($urandom_range(0, ALPHABET - 1));
    endfunction

    // ------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------

    // Present one item after a random gap, hold it until taken, then predict
    task automatic send_item(input pfc_pkg::t_in_item it);
        int gap;
        if ($urandom_range(0, 31) == 0) begin
            in_burst = !in_burst;
        end
        gap = in_burst ? 0 : $urandom_range(0, 7);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_item  <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        grid_cipher_step(it);
    endtask

    // Drop valid, wait for every owed result, then let the pipeline empty
    task automatic drain_block();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_pairs.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Width changes only on an idle block
    task automatic write_columns(input logic [COLS_W-1:0] value);
        drain_block();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        columns_reg = value;
        key_syms.delete();
    endtask

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("%0t ns: mismatch on %s: got %0d, want %0d", $time, what, got, want);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-picked items: field extremes, each opcode and every Playfair rule
    task automatic test_directed();
        // Corner cells of the full grid; the rectangle lands on two empty cells
        send_item(load_item(7'd127, 3'd7, 4'd15));
        send_item(load_item(7'd0, 3'd0, 4'd0));
        send_item(pair_item(pfc_pkg::OP_ENCODE, 7'd127, 7'd0, 1'b0));
        send_item(pair_item(pfc_pkg::OP_NONE, 7'd127, 7'd127, 1'b1));

        // Shrink to 2 x 4: symbol 127 now sits outside the grid, so it is absent
        write_columns(5'd4);
        send_item(pair_item(pfc_pkg::OP_ENCODE, 7'd127, 7'd0, 1'b0));

        // Fill the grid: row 0 = 10..13, row 1 = 14..17 (10 evicts symbol 0)
        for (int i = 0; i < 8; i++) begin
            send_item(load_item(SYM_W'(10 + i), ROW_W'(i / 4), COL_W'(i % 4)));
        end
        send_item(pair_item(pfc_pkg::OP_ENCODE, 7'd10, 7'd11, 1'b0));   // same row
        send_item(pair_item(pfc_pkg::OP_ENCODE, 7'd13, 7'd10, 1'b0));   // same row, wrap right
        send_item(pair_item(pfc_pkg::OP_ENCODE, 7'd11, 7'd15, 1'b0));   // same column, wrap down
        send_item(pair_item(pfc_pkg::OP_ENCODE, 7'd10, 7'd15, 1'b0));   // rectangle
        send_item(pair_item(pfc_pkg::OP_DECODE, 7'd10, 7'd11, 1'b0));   // same row, wrap left
        send_item(pair_item(pfc_pkg::OP_DECODE, 7'd11, 7'd15, 1'b0));   // same column, wrap up

        // Odd tail while symbol 0 is not in the key
        send_item(pair_item(pfc_pkg::OP_ENCODE, 7'd11, 7'd99, 1'b1));

        // Loads past the last row and past the last column: both dropped
        send_item(load_item(7'd20, 3'd2, 4'd1));
        send_item(load_item(7'd21, 3'd1, 4'd4));

        // Put 0 over 17, then an odd tail finds it
        send_item(load_item(7'd0, 3'd1, 4'd3));
        send_item(pair_item(pfc_pkg::OP_ENCODE, 7'd12, 7'd99, 1'b1));

        // Move 10 onto 16: its old cell empties, so the rectangle hits a hole
        send_item(load_item(7'd10, 3'd1, 4'd2));
        send_item(pair_item(pfc_pkg::OP_ENCODE, 7'd11, 7'd14, 1'b0));
    endtask

    // Load up to KEY_LOAD_CAP cells of the current grid in random order with distinct symbols
    task automatic load_random_key();
        int cols, cells, loads, pick, tmp;
        int sym_order [ALPHABET];
        int cell_order [CELL_COUNT];
        cols  = grid_width();
        cells = cols * (cols / 2);
        loads = (cells > KEY_LOAD_CAP) ? KEY_LOAD_CAP : cells;
        for (int i = 0; i < ALPHABET; i++) begin
            sym_order[i] = i;
        end
        for (int i = ALPHABET - 1; i > 0; i--) begin
            pick = $urandom_range(0, i);
            tmp = sym_order[i]; sym_order[i] = sym_order[pick]; sym_order[pick] = tmp;
        end
        for (int i = 0; i < cells; i++) begin
            cell_order[i] = (i / cols) * GRID_STRIDE + (i % cols);
        end
        for (int i = cells - 1; i > 0; i--) begin
            pick = $urandom_range(0, i);
            tmp = cell_order[i]; cell_order[i] = cell_order[pick]; cell_order[pick] = tmp;
        end
        for (int i = 0; i < loads; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                // Stray load anywhere, often outside the grid
                send_item(load_item(SYM_W'($urandom), ROW_W'($urandom), COL_W'($urandom)));
            end else begin
                send_item(load_item(SYM_W'(sym_order[i]),
                                    ROW_W'(cell_order[i] / GRID_STRIDE),
                                    COL_W'(cell_order[i] % GRID_STRIDE)));
                key_syms = {key_syms, SYM_W'(sym_order[i])};
            end
        end
    endtask

    // Pairs drawn mostly from the key, with stray loads and dead opcodes mixed in
    task automatic stream_pairs(input int count);
        int roll;
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(0, 19);
            if (roll == 0) begin
                send_item(pair_item(pfc_pkg::OP_NONE, SYM_W'($urandom), SYM_W'($urandom),
                                    1'($urandom)));
            end else if (roll == 1) begin
                send_item(load_item(pick_symbol(), ROW_W'($urandom), COL_W'($urandom)));
            end else begin
                send_item(pair_item($urandom_range(0, 1) ? pfc_pkg::OP_ENCODE
                                                         : pfc_pkg::OP_DECODE,
                                    pick_symbol(), pick_symbol(),
                                    $urandom_range(0, 9) == 0));
            end
        end
    endtask

    // One key per width; the list holds both extremes, odd and out-of-range values.
    // Symbols of an earlier, wider key stay behind outside the smaller grids.
    task automatic test_key_phases();
        logic [COLS_W-1:0] widths [11];
        widths = '{5'd2, 5'd4, 5'd6, 5'd8, 5'd16, 5'd7, 5'd0, 5'd31, 5'd12, 5'd3, 5'd16};
        foreach (widths[p]) begin
            write_columns(widths[p]);
            load_random_key();
            stream_pairs(PAIRS_PER_KEY);
        end
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // Drive the stall drawn for the next result, one cycle at a time
    always @(negedge i_clk) begin
        if (out_hold > 0) begin
            i_out_stall <= 1'b1;
            out_hold = out_hold - 1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Check each taken result against the oldest owed pair
    always @(posedge i_clk) begin
        pfc_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_pairs.size() == 0) begin
                flag_mismatch("result with nothing owed", int'(o_out_item), -1);
            end else begin
                want = pending_pairs.pop_front();
                if (o_out_item.out_first !== want.out_first) begin
                    flag_mismatch("out_first", o_out_item.out_first, want.out_first);
                end
                if (o_out_item.out_second !== want.out_second) begin
                    flag_mismatch("out_second", o_out_item.out_second, want.out_second);
                end
                if (o_out_item.status !== want.status) begin
                    flag_mismatch("status", o_out_item.status, want.status);
                end
            end
            if ($urandom_range(0, 31) == 0) begin
                out_burst = !out_burst;
            end
            out_hold = out_burst ? 0 : $urandom_range(0, 7);
        end
    end

    // Watchdog: end the run if neither channel moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t ns: no handshake for %0d cycles, %0d results owed",
                         $time, WATCHDOG_LIMIT, pending_pairs.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        i_in_valid   = 1'b0;
        i_in_item    = '0;
        i_out_stall  = 1'b0;
        error_count  = 0;
        quiet_cycles = 0;
        out_hold     = 0;
        in_burst     = 1'b0;
        out_burst    = 1'b0;

        // Model starts empty at the reset width
        columns_reg = pfc_pkg::COLS_RESET;
        foreach (cell_of_symbol[i]) begin
            cell_of_symbol[i] = 0;
        end
        foreach (symbol_in_cell[i]) begin
            symbol_in_cell[i] = 0;
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_key_phases();
        drain_block();

        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
